/* hw/rtl/hssd_pkg.sv */
// ----------------------------------------------------------------------------
// hssd_pkg
// Shared types, constants and helpers for the hall sensor speed decoder.
// ----------------------------------------------------------------------------
package hssd_pkg;

   localparam int unsigned TIME_WIDTH       = 32;
   localparam int unsigned TICKS_PER_MINUTE = 60000000;
   localparam int unsigned TICKS_W          = $clog2(TICKS_PER_MINUTE + 1);
   localparam int unsigned SPR_W            = 12;
   localparam int unsigned SPEED_W          = 16;
   localparam int unsigned DEN_W            = TIME_WIDTH + SPR_W;
   localparam int unsigned QUOT_W           = SPEED_W + 1;
   localparam int unsigned DSH_W            = DEN_W + SPEED_W;
   localparam int unsigned CNT_W            = $clog2(QUOT_W);

   localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
   localparam logic [SPEED_W-1:0] ABSURD_MARGIN = SPEED_W'(10);

   // register indexes
   localparam logic [1:0] REG_STEPS_PER_REV = 2'd0;
   localparam logic [1:0] REG_MAX_RPM       = 2'd1;
   localparam logic [1:0] REG_RESET_COUNT   = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_PATTERN = 2'd1;
   localparam logic [1:0] ERR_STEP    = 2'd2;

   // hall patterns
   localparam logic [2:0] HALL_ALL_LOW  = 3'b000;
   localparam logic [2:0] HALL_ALL_HIGH = 3'b111;

   localparam logic [0:0] FUNC_EDGE  = 1'b0;
   localparam logic [0:0] FUNC_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   // six-step position of a valid hall pattern
   function automatic logic [2:0] step_of(input logic [2:0] code);
      logic [2:0] idx;
      case (code)
         3'b010:  idx = 3'd0;
         3'b011:  idx = 3'd1;
         3'b001:  idx = 3'd2;
         3'b101:  idx = 3'd3;
         3'b100:  idx = 3'd4;
         default: idx = 3'd5;
      endcase
      return idx;
   endfunction

   // (idx - prev) mod 6
   function automatic logic [2:0] step_diff(input logic [2:0] idx, input logic [2:0] prev);
      logic [3:0] s;
      s = {1'b0, idx} + 4'd6 - {1'b0, prev};
      if (s >= 4'd6) begin
         s = s - 4'd6;
      end
      return s[2:0];
   endfunction

endpackage

/* hw/rtl/hall_sensor_speed_decoder.sv */
// ----------------------------------------------------------------------------
// hall_sensor_speed_decoder
// Decodes hall edges into six-step positions, measures speed with a serial
// divider and filters the speed on query.
// ----------------------------------------------------------------------------
// Flow: a query, an invalid pattern, or an edge that is not a single step or that
//   has a zero interval or zero steps per rev, goes from decode straight to ST_DONE; a
//   measured step goes through decode, one multiply, 17 restoring divide iterations on
//   one compare/subtract unit, then ST_DONE. Throughput: one item at a time;
//   req_stall is high from accept until the result has been loaded into the output register.
// Reset: synchronous, active high; control, decoder and filter state cleared, registers to defaults.
module hall_sensor_speed_decoder
   import hssd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic                  req_hall_a,
   input  logic                  req_hall_b,
   input  logic                  req_hall_c,
   input  logic [TIME_WIDTH-1:0] req_now_us,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SPEED_W-1:0]    rsp_speed_rpm,
   output logic [2:0]            rsp_hall_code,
   output logic [1:0]            rsp_error_code,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [SPEED_W-1:0]    csr_wdata
);

   state_type state_ff, state_in;

   // configuration
   logic [SPR_W-1:0]   spr_ff;
   logic [SPEED_W-1:0] max_rpm_ff;
   logic [SPEED_W-1:0] reset_count_ff;

   // captured item
   logic                  func_ff;
   logic [2:0]            code_ff;
   logic [TIME_WIDTH-1:0] now_ff;

   // decoder and filter state
   logic [2:0]            prev_index_ff;
   logic                  index_seen_ff;
   logic [TIME_WIDTH-1:0] last_edge_ff;
   logic [SPEED_W-1:0]    raw_speed_ff;
   logic [SPEED_W-1:0]    plausible_ff;
   logic                  seeded_ff;
   logic [SPEED_W-1:0]    stale_prev_ff;
   logic [SPEED_W-1:0]    stale_count_ff;
   logic [1:0]            error_ff;
   logic [2:0]            last_hall_ff;

   // divider
   logic [TIME_WIDTH-1:0] dt_ff;
   logic [DSH_W-1:0]      dsh_ff;
   logic [TICKS_W-1:0]    rem_ff;
   logic [SPEED_W-1:0]    quot_ff;
   logic [CNT_W-1:0]      cnt_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [SPEED_W-1:0]    rsp_speed_ff;
   logic [2:0]            rsp_hall_ff;
   logic [1:0]            rsp_error_ff;

   // decode
   logic                  is_edge;
   logic                  bad_pattern;
   logic [2:0]            idx;
   logic [2:0]            prev_eff;
   logic [2:0]            diff;
   logic                  step_ok;
   logic                  step_jump;
   logic [TIME_WIDTH-1:0] dt;
   logic                  fast_path;
   logic                  need_div;

   // query filter
   logic [SPEED_W-1:0]    held;
   logic                  absurd;
   logic [SPEED_W-1:0]    v_abs;
   logic [SPEED_W-1:0]    cnt_next;
   logic                  stale_fire;
   logic [SPEED_W-1:0]    v_out;

   // divide step
   logic                  div_ge;
   logic [DEN_W-1:0]      product;

   // control
   logic                  accept;
   logic                  out_free;
   logic                  load_rsp;
   logic                  csr_write;

   always_comb begin
      is_edge     = (func_ff == FUNC_EDGE);
      bad_pattern = (code_ff == HALL_ALL_LOW) || (code_ff == HALL_ALL_HIGH);
      idx         = step_of(code_ff);
      prev_eff    = index_seen_ff ? prev_index_ff : idx;
      diff        = step_diff(idx, prev_eff);
      step_ok     = (diff == 3'd1) || (diff == 3'd5);
      step_jump   = (diff != 3'd0) && !step_ok;
      dt          = now_ff - last_edge_ff;
      fast_path   = (dt == '0) || (spr_ff == '0);
      need_div    = is_edge && !bad_pattern && step_ok && !fast_path;

      held       = seeded_ff ? plausible_ff : raw_speed_ff;
      absurd     = {1'b0, raw_speed_ff} > ({1'b0, max_rpm_ff} + {1'b0, ABSURD_MARGIN});
      v_abs      = absurd ? held : raw_speed_ff;
      if (stale_prev_ff == v_abs) begin
         cnt_next = (stale_count_ff == SPEED_MAX) ? stale_count_ff : stale_count_ff + 1'b1;
      end else begin
         cnt_next = '0;
      end
      stale_fire = cnt_next > reset_count_ff;
      v_out      = stale_fire ? '0 : v_abs;

      product = DEN_W'(dt_ff) * DEN_W'(spr_ff);
      div_ge  = DSH_W'(rem_ff) >= dsh_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = need_div ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      csr_ready = 1'b1;
      out_free  = !rsp_valid_ff || !rsp_stall;
      load_rsp  = (state_ff == ST_DONE) && out_free;
      accept    = req_valid && (state_ff == ST_IDLE);
      csr_write = csr_valid && csr_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_speed_rpm  = rsp_speed_ff;
   assign rsp_hall_code  = rsp_hall_ff;
   assign rsp_error_code = rsp_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         spr_ff         <= SPR_W'(6);
         max_rpm_ff     <= SPEED_W'(6000);
         reset_count_ff <= SPEED_W'(100);
         prev_index_ff  <= '0;
         index_seen_ff  <= 1'b0;
         last_edge_ff   <= '0;
         raw_speed_ff   <= '0;
         plausible_ff   <= '0;
         seeded_ff      <= 1'b0;
         stale_prev_ff  <= '0;
         stale_count_ff <= '0;
         error_ff       <= ERR_NONE;
         last_hall_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_write) begin
            case (csr_index)
               REG_STEPS_PER_REV: spr_ff         <= csr_wdata[SPR_W-1:0];
               REG_MAX_RPM:       max_rpm_ff     <= csr_wdata;
               REG_RESET_COUNT:   reset_count_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (state_ff == ST_EXEC) begin
            if (is_edge) begin
               last_hall_ff <= code_ff;
               if (bad_pattern) begin
                  error_ff <= ERR_PATTERN;
               end else begin
                  index_seen_ff <= 1'b1;
                  prev_index_ff <= idx;
                  if (step_ok) begin
                     last_edge_ff <= now_ff;
                     if (fast_path) begin
                        raw_speed_ff <= SPEED_MAX;
                     end
                  end else if (step_jump) begin
                     error_ff <= ERR_STEP;
                  end
               end
            end else begin
               seeded_ff      <= 1'b1;
               plausible_ff   <= v_abs;
               stale_count_ff <= stale_fire ? '0 : cnt_next;
               stale_prev_ff  <= v_out;
               raw_speed_ff   <= v_out;
            end
         end

         if ((state_ff == ST_DIV) && (cnt_ff == '0)) begin
            raw_speed_ff <= quot_ff[SPEED_W-1] ? SPEED_MAX : {quot_ff[SPEED_W-2:0], div_ge};
         end

         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and divider datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         code_ff <= {req_hall_a, req_hall_b, req_hall_c};
         now_ff  <= req_now_us;
      end

      if (state_ff == ST_EXEC) begin
         dt_ff <= dt;
      end

      if (state_ff == ST_MUL) begin
         dsh_ff  <= {product, SPEED_W'(0)};
         rem_ff  <= TICKS_W'(TICKS_PER_MINUTE);
         quot_ff <= '0;
         cnt_ff  <= CNT_W'(QUOT_W - 1);
      end else if (state_ff == ST_DIV) begin
         if (div_ge) begin
            rem_ff <= rem_ff - dsh_ff[TICKS_W-1:0];
         end
         dsh_ff  <= dsh_ff >> 1;
         quot_ff <= {quot_ff[SPEED_W-2:0], div_ge};
         cnt_ff  <= cnt_ff - 1'b1;
      end

      if (load_rsp) begin
         rsp_speed_ff <= raw_speed_ff;
         rsp_hall_ff  <= last_hall_ff;
         rsp_error_ff <= error_ff;
      end
   end

endmodule

/* sim/hssd_result_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hssd_result_check
// Watches the request, result and register channels of the hall sensor speed
// decoder, keeps its own model of the decoder state, predicts each result and
// compares it field by field with what the decoder returns.
// ----------------------------------------------------------------------------
module hssd_result_check
   import hssd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_func,
   input  logic                  req_hall_a,
   input  logic                  req_hall_b,
   input  logic                  req_hall_c,
   input  logic [TIME_WIDTH-1:0] req_now_us,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [SPEED_W-1:0]    rsp_speed_rpm,
   input  logic [2:0]            rsp_hall_code,
   input  logic [1:0]            rsp_error_code,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [SPEED_W-1:0]    csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   localparam logic [SPR_W-1:0]   DEFAULT_SPR         = SPR_W'(6);
   localparam logic [SPEED_W-1:0] DEFAULT_MAX_RPM     = SPEED_W'(6000);
   localparam logic [SPEED_W-1:0] DEFAULT_RESET_COUNT = SPEED_W'(100);

   typedef struct packed {
      logic [SPEED_W-1:0] speed_rpm;
      logic [2:0]         hall_code;
      logic [1:0]         error_code;
   } decoder_result_type;

   decoder_result_type predicted_results[$];

   // configuration copy
   logic [SPR_W-1:0]      cfg_spr;
   logic [SPEED_W-1:0]    cfg_max_rpm;
   logic [SPEED_W-1:0]    cfg_reset_count;

   // decoder state copy
   logic [2:0]            last_position;
   logic                  position_valid;
   logic [TIME_WIDTH-1:0] last_step_time;
   logic [SPEED_W-1:0]    speed_now;
   logic [SPEED_W-1:0]    held_speed;
   logic                  held_seeded;
   logic [SPEED_W-1:0]    repeat_speed;
   logic [SPEED_W-1:0]    repeat_count;
   logic [1:0]            sticky_error;
   logic [2:0]            hall_seen;

   int mismatches;

   function automatic logic [2:0] position_of(input logic [2:0] code);
      case (code)
         3'b010:  return 3'd0;
         3'b011:  return 3'd1;
         3'b001:  return 3'd2;
         3'b101:  return 3'd3;
         3'b100:  return 3'd4;
         default: return 3'd5;
      endcase
   endfunction

   function automatic logic [SPEED_W-1:0] rpm_from_interval(input logic [TIME_WIDTH-1:0] dt,
                                                             input logic [SPR_W-1:0] spr);
      logic [63:0] den;
      logic [63:0] quot;
      if (dt == '0 || spr == '0) begin
         return SPEED_MAX;
      end
      den  = 64'(dt) * 64'(spr);
      quot = 64'(TICKS_PER_MINUTE) / den;
      return (quot > 64'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
   endfunction

   task automatic clear_model();
      cfg_spr         = DEFAULT_SPR;
      cfg_max_rpm     = DEFAULT_MAX_RPM;
      cfg_reset_count = DEFAULT_RESET_COUNT;
      last_position   = '0;
      position_valid  = 1'b0;
      last_step_time  = '0;
      speed_now       = '0;
      held_speed      = '0;
      held_seeded     = 1'b0;
      repeat_speed    = '0;
      repeat_count    = '0;
      sticky_error    = ERR_NONE;
      hall_seen       = '0;
   endtask

   task automatic decode_hall_edge(input logic [2:0] code, input logic [TIME_WIDTH-1:0] now);
      logic [2:0]            pos;
      int                    diff;
      logic [TIME_WIDTH-1:0] dt;
      hall_seen = code;
      if (code == HALL_ALL_LOW || code == HALL_ALL_HIGH) begin
         sticky_error = ERR_PATTERN;
      end else begin
         pos = position_of(code);
         if (!position_valid) begin
            last_position  = pos;
            position_valid = 1'b1;
         end
         diff = (int'(pos) + 6 - int'(last_position)) % 6;
         if (diff == 1 || diff == 5) begin
            dt             = now - last_step_time;
            last_step_time = now;
            speed_now      = rpm_from_interval(dt, cfg_spr);
         end else if (diff != 0) begin
            sticky_error = ERR_STEP;
         end
         last_position = pos;
      end
   endtask

   task automatic filter_speed_query();
      logic [SPEED_W-1:0] v;
      v = speed_now;
      if (!held_seeded) begin
         held_speed  = v;
         held_seeded = 1'b1;
      end
      if ({1'b0, v} > ({1'b0, cfg_max_rpm} + {1'b0, ABSURD_MARGIN})) begin
         v = held_speed;
      end
      held_speed = v;
      if (repeat_speed == v) begin
         if (repeat_count != SPEED_MAX) begin
            repeat_count = repeat_count + 1'b1;
         end
      end else begin
         repeat_count = '0;
      end
      if (repeat_count > cfg_reset_count) begin
         v            = '0;
         repeat_count = '0;
      end
      repeat_speed = v;
      speed_now    = v;
   endtask

   initial begin
      mismatches    = 0;
      fail_count    = 0;
      pending_count = 0;
      clear_model();
   end

   always @(posedge clock) begin : monitor
      decoder_result_type want;
      if (reset) begin
         clear_model();
         predicted_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_STEPS_PER_REV: cfg_spr         = csr_wdata[SPR_W-1:0];
               REG_MAX_RPM:       cfg_max_rpm     = csr_wdata;
               REG_RESET_COUNT:   cfg_reset_count = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               $error("unexpected result: speed_rpm %0d hall_code %0d error_code %0d",
                      rsp_speed_rpm, rsp_hall_code, rsp_error_code);
               mismatches++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_speed_rpm !== want.speed_rpm) begin
                  $error("speed_rpm expected %0d actual %0d", want.speed_rpm, rsp_speed_rpm);
                  mismatches++;
               end
               if (rsp_hall_code !== want.hall_code) begin
                  $error("hall_code expected %0d actual %0d", want.hall_code, rsp_hall_code);
                  mismatches++;
               end
               if (rsp_error_code !== want.error_code) begin
                  $error("error_code expected %0d actual %0d", want.error_code, rsp_error_code);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_EDGE) begin
               decode_hall_edge({req_hall_a, req_hall_b, req_hall_c}, req_now_us);
            end else begin
               filter_speed_query();
            end
            want.speed_rpm  = speed_now;
            want.hall_code  = hall_seen;
            want.error_code = sticky_error;
            predicted_results.push_back(want);
         end
      end
      fail_count    = mismatches;
      pending_count = predicted_results.size();
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the hall sensor speed decoder with a directed sequence and then with
// random, mostly well-formed rotation sequences under several register
// settings, with random gaps on the request channel and random stalls on the result channel.
// ----------------------------------------------------------------------------
module tb_top
   import hssd_pkg::*;
;

   localparam int         IDLE_LIMIT   = 4000;
   localparam int         DRAIN_CYCLES = 30;
   localparam logic [1:0] REG_UNUSED   = 2'd3;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic                  req_func       = FUNC_EDGE;
   logic                  req_hall_a     = 1'b0;
   logic                  req_hall_b     = 1'b0;
   logic                  req_hall_c     = 1'b0;
   logic [TIME_WIDTH-1:0] req_now_us     = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [SPEED_W-1:0]    rsp_speed_rpm;
   logic [2:0]            rsp_hall_code;
   logic [1:0]            rsp_error_code;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index      = '0;
   logic [SPEED_W-1:0]    csr_wdata      = '0;

   int fail_count;
   int pending_count;
   int idle_cycles = 0;

   // rotation tracking for the random part
   int                    rotor_pos = 0;
   int                    rotor_dir = 1;
   logic [TIME_WIDTH-1:0] rotor_time = '0;

   always #6 clock = ~clock;

   hall_sensor_speed_decoder DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_hall_a     (req_hall_a),
      .req_hall_b     (req_hall_b),
      .req_hall_c     (req_hall_c),
      .req_now_us     (req_now_us),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_speed_rpm  (rsp_speed_rpm),
      .rsp_hall_code  (rsp_hall_code),
      .rsp_error_code (rsp_error_code),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   hssd_result_check u_result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_hall_a     (req_hall_a),
      .req_hall_b     (req_hall_b),
      .req_hall_c     (req_hall_c),
      .req_now_us     (req_now_us),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_speed_rpm  (rsp_speed_rpm),
      .rsp_hall_code  (rsp_hall_code),
      .rsp_error_code (rsp_error_code),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   function automatic logic [2:0] hall_code_at(input int pos);
      case (pos)
         0:       return 3'b010;
         1:       return 3'b011;
         2:       return 3'b001;
         3:       return 3'b101;
         4:       return 3'b100;
         default: return 3'b110;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [TIME_WIDTH-1:0] pick_interval();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return TIME_WIDTH'($urandom_range(0, 3));
      if (r < 50) return TIME_WIDTH'($urandom_range(100, 5000));
      if (r < 90) return TIME_WIDTH'($urandom_range(1000, 100000));
      return TIME_WIDTH'($urandom());
   endfunction

   task automatic send_item(input logic func, input logic [2:0] code,
                            input logic [TIME_WIDTH-1:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= func;
      req_hall_a <= code[2];
      req_hall_b <= code[1];
      req_hall_c <= code[0];
      req_now_us <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_edge(input logic [2:0] code, input logic [TIME_WIDTH-1:0] now);
      send_item(FUNC_EDGE, code, now);
   endtask

   task automatic send_query();
      send_item(FUNC_QUERY, 3'($urandom()), TIME_WIDTH'($urandom()));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // valid stays high across the batch and drops after the last write
   task automatic write_register(input logic [1:0] index, input logic [SPEED_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [SPR_W-1:0] spr, input logic [SPEED_W-1:0] max_rpm,
                            input logic [SPEED_W-1:0] reset_count);
      wait_drained();
      write_register(REG_STEPS_PER_REV, {4'($urandom()), spr});
      write_register(REG_MAX_RPM, max_rpm);
      write_register(REG_UNUSED, SPEED_W'($urandom()));
      write_register(REG_RESET_COUNT, reset_count);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count);
      int sent;
      int r;
      int n;
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            if ($urandom_range(0, 9) == 0) rotor_dir = -rotor_dir;
            rotor_pos  = (rotor_pos + rotor_dir + 6) % 6;
            rotor_time = rotor_time + pick_interval();
            send_edge(hall_code_at(rotor_pos), rotor_time);
            sent++;
         end else if (r < 80) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               send_query();
               sent++;
            end
         end else if (r < 86) begin
            rotor_time = rotor_time + pick_interval();
            send_edge(hall_code_at(rotor_pos), rotor_time);
            sent++;
         end else if (r < 92) begin
            send_edge($urandom_range(0, 1) ? HALL_ALL_HIGH : HALL_ALL_LOW,
                      TIME_WIDTH'($urandom()));
            sent++;
         end else if (r < 97) begin
            rotor_pos  = (rotor_pos + $urandom_range(2, 4)) % 6;
            rotor_time = rotor_time + pick_interval();
            send_edge(hall_code_at(rotor_pos), rotor_time);
            sent++;
         end else begin
            rotor_time = TIME_WIDTH'($urandom());
            rotor_pos  = $urandom_range(0, 5);
            send_edge(3'($urandom()), rotor_time);
            sent++;
         end
      end
   endtask

   // result side: short stalls, free-running stretches and long hold-offs
   initial begin : result_sink
      int n;
      int r;
      int seg;
      seg = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         seg++;
         r = $urandom_range(0, 99);
         if (seg == 60) begin
            rsp_stall <= 1'b1;
            n = 400;
         end else if (r < 2) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(50, 150);
         end else if (r < 50) begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 20);
         end else if (r < 90) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b0;
            n = $urandom_range(40, 100);
         end
         repeat (n) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("hall_sensor_speed_decoder regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset settings
      send_query();                             // first query seeds the held value
      send_edge(HALL_ALL_LOW, 32'd7);
      send_edge(HALL_ALL_HIGH, 32'd8);
      send_edge(3'b010, 32'h0000_0100);         // first valid edge
      send_edge(3'b010, 32'h0000_0200);         // same step
      send_edge(3'b011, 32'h0000_0000);         // zero interval
      send_edge(3'b001, 32'd2000);
      send_query();
      send_edge(3'b011, 32'd2003);              // reverse step, saturates
      send_query();                             // absurd reading held
      send_query();
      send_edge(3'b101, 32'd2100);              // jump of two
      send_edge(3'b010, 32'd2200);              // jump of three
      send_edge(3'b110, 32'hFFFF_FFF0);         // reverse wrap of position
      send_edge(3'b010, 32'h0000_0F00);         // timestamp wraps
      send_edge(HALL_ALL_LOW, 32'hFFFF_FFFF);   // pattern error over step error
      send_edge(3'b100, 32'hFFFF_FFFF);
      send_edge(3'b101, 32'hFFFF_FFFF);
      repeat (6) send_query();

      configure(12'd6, 16'd6000, 16'd2);
      run_random(170);
      configure(12'd1, 16'hFFFF, 16'd0);
      run_random(170);
      configure(12'hFFF, 16'd0, 16'hFFFF);
      run_random(170);
      configure(12'd0, 16'd3000, 16'd5);
      run_random(170);
      configure(SPR_W'($urandom_range(1, 12)), SPEED_W'($urandom()),
                SPEED_W'($urandom_range(0, 10)));
      run_random(170);
      configure(12'd6, 16'd6000, 16'd100);
      run_random(170);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("hall_sensor_speed_decoder regression: pass");
      end else begin
         $display("hall_sensor_speed_decoder regression: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/hssd_pkg.sv
hw/rtl/hall_sensor_speed_decoder.sv
sim/hssd_result_check.sv
sim/tb_top.sv
